@@ design/eiph_pkg.sv @@
// Package for the Ethernet/VLAN/IPv4/TCP header parser.
// Shared types and constants; no dependencies.
`timescale 1ns / 1ps
package eiph_pkg;
  localparam int unsigned MaxLen = 16384;
  localparam int CntW = 17;
  localparam logic [15:0] EtypeVlan = 16'h8100;
  localparam logic [15:0] EtypeIpv4 = 16'h0800;
  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [3:0] NibbleMask = 4'hF;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_SHORT_ETH = 3'd1,
    ST_NOT_IPV4 = 3'd2,
    ST_NOT_TCP = 3'd3,
    ST_TCP_SHORT = 3'd4,
    ST_TOO_LONG = 3'd5
  } status_e;

  typedef struct packed {
    logic [2:0] status;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [14:0] poff;
    logic [14:0] plen;
  } result_t;
endpackage

@@ design/eth_ipv4_tcp_header_parser.sv @@
// Top level of the Ethernet/VLAN/IPv4/TCP header parser.
// Depends on eiph_pkg, eiph_front and eiph_back.
//
// Input channel: one frame byte per beat (data_byte_i, last_byte_i) under
// in_valid_i/in_ready_o. Output channel: one result per frame under
// out_valid_o/out_ready_i, carrying status, addresses, ports and payload
// offset/length.
// Throughput: one byte per cycle while in_ready_o is high. The front parser
// updates its state every accepted beat; a frame's result is registered in
// the front result register at the last beat, then written into a 4-entry
// queue, from which the output channel takes it.
// When the receiver stalls, results collect in the queue; in_ready_o drops
// only when the queue holds three or more results, so bytes keep streaming
// through short stalls.
// Reset clears the parser to the Ethernet phase and empties the queue.
// A frame longer than 16384 bytes reports status 5 regardless of content.
`timescale 1ns / 1ps
module eth_ipv4_tcp_header_parser (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic last_byte_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [2:0] status_o,
  output logic [31:0] source_address_o,
  output logic [31:0] dest_address_o,
  output logic [15:0] source_port_o,
  output logic [15:0] dest_port_o,
  output logic [14:0] payload_offset_o,
  output logic [14:0] payload_length_o
);
  import eiph_pkg::*;
  logic res_valid, afull;
  result_t res, q;

  assign in_ready_o = !afull;

  eiph_front u_front (
    .clk_i, .rst_ni, .in_valid_i(in_valid_i && in_ready_o),
    .data_byte_i, .last_byte_i, .res_valid_o(res_valid), .res_o(res)
  );

  eiph_back u_back (
    .clk_i, .rst_ni, .wr_i(res_valid), .wdata_i(res), .almost_full_o(afull),
    .out_valid_o, .out_ready_i, .rdata_o(q)
  );

  assign status_o = q.status;
  assign source_address_o = q.src_addr;
  assign dest_address_o = q.dst_addr;
  assign source_port_o = q.sport;
  assign dest_port_o = q.dport;
  assign payload_offset_o = q.poff;
  assign payload_length_o = q.plen;
endmodule

@@ design/eiph_front.sv @@
// Front end: per-byte header parse state machine, one beat per cycle.
// Depends on eiph_pkg. Emits one result on the last beat of a frame.
`timescale 1ns / 1ps
module eiph_front (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic [7:0] data_byte_i,
  input  logic last_byte_i,
  output logic res_valid_o,
  output eiph_pkg::result_t res_o
);
  import eiph_pkg::*;

  typedef enum logic [6:0] {
    PH_ETH = 7'b0000001,
    PH_VLAN = 7'b0000010,
    PH_IP = 7'b0000100,
    PH_IPOPT = 7'b0001000,
    PH_TCP = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_DONE = 7'b1000000
  } phase_e;

  phase_e phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0] etype_q, etype_d;
  logic [CntW-1:0] l3_q, l3_d, l4_q, l4_d;
  logic [5:0] ihl_q, ihl_d, thl_q, thl_d;
  logic [7:0] proto_q, proto_d;
  logic [31:0] sa_q, sa_d, da_q, da_d;
  logic [15:0] sp_q, sp_d, dp_q, dp_d;
  logic [2:0] fail_q, fail_d;
  logic [CntW-1:0] o3, o4, poff;
  logic [15:0] etype_full;
  logic [2:0] status;
  result_t res_d;

  assign o3 = cnt_q - l3_q;
  assign o4 = cnt_q - l4_q;
  assign etype_full = {etype_q[15:8], data_byte_i};
  assign poff = l4_q + CntW'(thl_q);

  always_comb begin
    phase_d = phase_q; etype_d = etype_q; l3_d = l3_q; l4_d = l4_q;
    ihl_d = ihl_q; thl_d = thl_q; proto_d = proto_q; sa_d = sa_q; da_d = da_q;
    sp_d = sp_q; dp_d = dp_q; fail_d = fail_q; cnt_d = cnt_q;
    if (cnt_q < CntW'(MaxLen)) begin
      case (phase_q)
        PH_ETH, PH_VLAN: begin
          if ((phase_q == PH_ETH && cnt_q == CntW'(12)) ||
              (phase_q == PH_VLAN && o3 == CntW'(2)))
            etype_d = {data_byte_i, 8'h00};
          if ((phase_q == PH_ETH && cnt_q == CntW'(13)) ||
              (phase_q == PH_VLAN && o3 == CntW'(3))) begin
            etype_d = etype_full;
            l3_d = (phase_q == PH_ETH) ? CntW'(14) : l3_q + CntW'(4);
            if (etype_full == EtypeVlan) phase_d = PH_VLAN;
            else if (etype_full == EtypeIpv4) phase_d = PH_IP;
            else begin fail_d = ST_NOT_IPV4; phase_d = PH_DONE; end
          end
        end
        PH_IP: begin
          if (o3 == '0) ihl_d = {data_byte_i[3:0] & NibbleMask, 2'b00};
          if (o3 == CntW'(9)) proto_d = data_byte_i;
          if (o3 >= CntW'(12) && o3 <= CntW'(15)) sa_d = {sa_q[23:0], data_byte_i};
          if (o3 >= CntW'(16) && o3 <= CntW'(19)) da_d = {da_q[23:0], data_byte_i};
          if (o3 == CntW'(19)) begin
            if (ihl_q < 6'd20 || proto_q != ProtoTcp) begin
              fail_d = ST_NOT_TCP; phase_d = PH_DONE;
            end else begin
              l4_d = l3_q + CntW'(ihl_q);
              phase_d = (ihl_q == 6'd20) ? PH_TCP : PH_IPOPT;
            end
          end
        end
        PH_IPOPT: if (cnt_q + CntW'(1) == l4_q) phase_d = PH_TCP;
        PH_TCP: begin
          if (o4 <= CntW'(1)) sp_d = {sp_q[7:0], data_byte_i};
          if (o4 == CntW'(2) || o4 == CntW'(3)) dp_d = {dp_q[7:0], data_byte_i};
          if (o4 == CntW'(12)) thl_d = {data_byte_i[7:4], 2'b00};
          if (o4 >= CntW'(19) && o4 + CntW'(1) >= CntW'(thl_q)) phase_d = PH_PAYLOAD;
        end
        default: ;
      endcase
    end
    if (cnt_q <= CntW'(MaxLen)) cnt_d = cnt_q + CntW'(1);

    if (cnt_d > CntW'(MaxLen)) status = ST_TOO_LONG;
    else begin
      case (phase_d)
        PH_ETH: status = ST_SHORT_ETH;
        PH_VLAN, PH_IP: status = ST_NOT_IPV4;
        PH_IPOPT: status = ST_NOT_TCP;
        PH_TCP: status = ST_TCP_SHORT;
        PH_PAYLOAD: status = ST_OK;
        default: status = fail_d;
      endcase
    end
    res_d = '0;
    res_d.status = status;
    if (status == ST_OK) begin
      res_d.src_addr = sa_d; res_d.dst_addr = da_d;
      res_d.sport = sp_d; res_d.dport = dp_d;
      res_d.poff = poff[14:0];
      res_d.plen = 15'(cnt_d - poff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ETH; cnt_q <= '0; etype_q <= '0; l3_q <= CntW'(14); l4_q <= '0;
      ihl_q <= '0; thl_q <= '0; proto_q <= '0; sa_q <= '0; da_q <= '0;
      sp_q <= '0; dp_q <= '0; fail_q <= '0; res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= in_valid_i && last_byte_i;
      if (in_valid_i) begin
        if (last_byte_i) begin
          phase_q <= PH_ETH; cnt_q <= '0; etype_q <= '0; l3_q <= CntW'(14);
          l4_q <= '0; ihl_q <= '0; thl_q <= '0; proto_q <= '0; sa_q <= '0;
          da_q <= '0; sp_q <= '0; dp_q <= '0; fail_q <= '0;
        end else begin
          phase_q <= phase_d; cnt_q <= cnt_d; etype_q <= etype_d; l3_q <= l3_d;
          l4_q <= l4_d; ihl_q <= ihl_d; thl_q <= thl_d; proto_q <= proto_d;
          sa_q <= sa_d; da_q <= da_d; sp_q <= sp_d; dp_q <= dp_d; fail_q <= fail_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && last_byte_i) res_o <= res_d;
  end
endmodule

@@ design/eiph_back.sv @@
// Back end: 4-entry result queue feeding the output channel.
// Depends on eiph_pkg.
`timescale 1ns / 1ps
module eiph_back (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  eiph_pkg::result_t wdata_i,
  output logic almost_full_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output eiph_pkg::result_t rdata_o
);
  import eiph_pkg::*;
  result_t mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic rd;

  assign out_valid_o = cnt_q != 3'd0;
  assign rd = out_valid_o && out_ready_i;
  assign rdata_o = mem_q[rp_q];
  // one result may still be in flight from the front register
  assign almost_full_o = cnt_q >= 3'd3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + 2'd1;
      if (rd) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'b00, wr_i} - {2'b00, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end
endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for eth_ipv4_tcp_header_parser.
// Builds frames byte by byte, predicts one result per frame in SV and
// compares every output beat. Depends on eiph_pkg and the parser RTL.
`timescale 1ns / 1ps
module tb_top;
  import eiph_pkg::*;

  typedef enum int unsigned {
    PH_ETH, PH_VLAN, PH_IP, PH_IPOPT, PH_TCP, PH_PAYLOAD, PH_DONE
  } phase_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned HoldCycles = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] data_byte = '0;
  logic last_byte = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic [31:0] src_addr, dst_addr;
  logic [15:0] rx_sport, rx_dport;
  logic [14:0] poff, plen;

  frame_byte_t byte_q[$];
  result_t     result_q[$];
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  logic        hold = 1'b0;

  // predictor state
  int unsigned pos, l3_off, ip_hlen, ip_proto, l4_off, tcp_hlen;
  logic [15:0] etype;
  logic [31:0] saddr, daddr;
  logic [15:0] sport, dport;
  logic [2:0]  fail_st;
  phase_e      phase;

  always #4 clk = ~clk;

  eth_ipv4_tcp_header_parser i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .data_byte_i     (data_byte),
    .last_byte_i     (last_byte),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (status),
    .source_address_o(src_addr),
    .dest_address_o  (dst_addr),
    .source_port_o   (rx_sport),
    .dest_port_o     (rx_dport),
    .payload_offset_o(poff),
    .payload_length_o(plen)
  );

  function automatic void clear_parser();
    pos = 0; phase = PH_ETH; etype = '0; l3_off = 14; ip_hlen = 0; ip_proto = 0;
    saddr = '0; daddr = '0; l4_off = 0; sport = '0; dport = '0; tcp_hlen = 0;
    fail_st = ST_OK;
  endfunction

  function automatic void type_done();
    if (etype == EtypeVlan) phase = PH_VLAN;
    else if (etype == EtypeIpv4) phase = PH_IP;
    else begin
      fail_st = ST_NOT_IPV4;
      phase = PH_DONE;
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b, int unsigned idx);
    int unsigned o;
    case (phase)
      PH_ETH: begin
        if (idx == 12) etype = {b, 8'h00};
        if (idx == 13) begin
          etype[7:0] = b;
          l3_off = 14;
          type_done();
        end
      end
      PH_VLAN: begin
        o = idx - l3_off;
        if (o == 2) etype = {b, 8'h00};
        if (o == 3) begin
          etype[7:0] = b;
          l3_off += 4;
          type_done();
        end
      end
      PH_IP: begin
        o = idx - l3_off;
        if (o == 0) ip_hlen = (b & NibbleMask) * 4;
        if (o == 9) ip_proto = b;
        if (o >= 12 && o <= 15) saddr = {saddr[23:0], b};
        if (o >= 16 && o <= 19) daddr = {daddr[23:0], b};
        if (o == 19) begin
          if (ip_hlen < 20 || ip_proto != ProtoTcp) begin
            fail_st = ST_NOT_TCP;
            phase = PH_DONE;
          end else begin
            l4_off = l3_off + ip_hlen;
            phase = (ip_hlen == 20) ? PH_TCP : PH_IPOPT;
          end
        end
      end
      PH_IPOPT: if (idx + 1 == l4_off) phase = PH_TCP;
      PH_TCP: begin
        o = idx - l4_off;
        if (o <= 1) sport = {sport[7:0], b};
        if (o == 2 || o == 3) dport = {dport[7:0], b};
        if (o == 12) tcp_hlen = (b >> 4) * 4;
        if (o >= 19 && o + 1 >= tcp_hlen) phase = PH_PAYLOAD;
      end
      default: ;
    endcase
  endfunction

  // advance the predictor by one accepted beat
  function automatic void predict_beat(logic [7:0] b, logic last);
    result_t r;
    int unsigned off;
    if (pos < MaxLen) parse_byte(b, pos);
    if (pos <= MaxLen) pos++;
    if (!last) return;
    r = '0;
    if (pos > MaxLen) r.status = ST_TOO_LONG;
    else begin
      case (phase)
        PH_ETH:     r.status = ST_SHORT_ETH;
        PH_VLAN:    r.status = ST_NOT_IPV4;
        PH_IP:      r.status = ST_NOT_IPV4;
        PH_IPOPT:   r.status = ST_NOT_TCP;
        PH_TCP:     r.status = ST_TCP_SHORT;
        PH_PAYLOAD: r.status = ST_OK;
        default:    r.status = fail_st;
      endcase
    end
    if (r.status == ST_OK) begin
      off = l4_off + tcp_hlen;
      r.src_addr = saddr;
      r.dst_addr = daddr;
      r.sport = sport;
      r.dport = dport;
      r.poff = off[14:0];
      r.plen = 15'(pos - off);
    end
    result_q.push_back(r);
    clear_parser();
  endfunction

  // cut < 1 keeps the whole frame
  task automatic build_frame(int nvlan, logic [15:0] ety, logic [3:0] ihl,
                             logic [7:0] proto, logic [3:0] doff, int paylen,
                             int cut);
    logic [7:0] f[$];
    frame_byte_t fb;
    int n;
    for (int k = 0; k < 12; k++) f.push_back(8'($urandom));
    for (int v = 0; v < nvlan; v++) begin
      f.push_back(EtypeVlan[15:8]); f.push_back(EtypeVlan[7:0]);
      f.push_back(8'($urandom)); f.push_back(8'($urandom));
    end
    f.push_back(ety[15:8]); f.push_back(ety[7:0]);
    n = (ihl > 5) ? ihl * 4 : 20;
    for (int k = 0; k < n; k++) begin
      if (k == 0) f.push_back({4'($urandom), ihl});
      else if (k == 9) f.push_back(proto);
      else f.push_back(8'($urandom));
    end
    n = (doff > 5) ? doff * 4 : 20;
    for (int k = 0; k < n; k++) begin
      if (k == 12) f.push_back({doff, 4'($urandom)});
      else f.push_back(8'($urandom));
    end
    for (int k = 0; k < paylen; k++) f.push_back(8'($urandom));
    if (cut > 0 && cut < f.size()) n = cut;
    else n = f.size();
    for (int k = 0; k < n; k++) begin
      fb.data = f[k];
      fb.last = (k == n - 1);
      byte_q.push_back(fb);
    end
  endtask

  task automatic report(string field, longint unsigned want, longint unsigned got);
    errors++;
    $display("mismatch %s: expected %0h got %0h at %0t", field, want, got, $realtime);
  endtask

  // sender: bursts with gaps, payload held until accepted
  int unsigned burst_left = 0, gap_left = 0;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_beat(data_byte, last_byte);
        void'(byte_q.pop_front());
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          in_valid <= 1'b1;
          data_byte <= byte_q[0].data;
          last_byte <= byte_q[0].last;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(1, 60);
            gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches mode now and then
  int unsigned mode = 0, mode_left = 0;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    case (mode)
      0: out_ready <= !hold;
      1: out_ready <= !hold && ($urandom_range(0, 1) == 1);
      default: out_ready <= !hold && ($urandom_range(0, 3) == 0);
    endcase
  end

  // long hold-off so the result queue fills and the input stalls
  initial begin
    wait (bytes_sent >= 600);
    @(posedge clk);
    hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold <= 1'b0;
  end

  always @(posedge clk) begin
    result_t r;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        report("unexpected beat", 0, status);
      end else begin
        r = result_q.pop_front();
        if (status !== r.status) report("status", r.status, status);
        if (src_addr !== r.src_addr) report("source_address", r.src_addr, src_addr);
        if (dst_addr !== r.dst_addr) report("dest_address", r.dst_addr, dst_addr);
        if (rx_sport !== r.sport) report("source_port", r.sport, rx_sport);
        if (rx_dport !== r.dport) report("dest_port", r.dport, rx_dport);
        if (poff !== r.poff) report("payload_offset", r.poff, poff);
        if (plen !== r.plen) report("payload_length", r.plen, plen);
      end
    end
  end

  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    clear_parser();
    // directed: each way a frame can end
    build_frame(0, EtypeIpv4, 5, ProtoTcp, 5, 0, 1);       // one byte
    build_frame(0, EtypeIpv4, 5, ProtoTcp, 5, 0, 13);      // short Ethernet
    build_frame(0, 16'h86DD, 5, ProtoTcp, 5, 4, -1);       // not IPv4
    build_frame(2, EtypeIpv4, 5, ProtoTcp, 5, 0, 17);      // ends inside VLAN tag
    build_frame(0, EtypeIpv4, 5, ProtoTcp, 5, 0, 25);      // IP header short
    build_frame(0, EtypeIpv4, 4, ProtoTcp, 5, 3, -1);      // IHL below 5
    build_frame(0, EtypeIpv4, 0, ProtoTcp, 5, 0, -1);
    build_frame(0, EtypeIpv4, 5, 8'd17, 5, 3, -1);         // not TCP
    build_frame(1, EtypeIpv4, 15, ProtoTcp, 5, 0, 60);     // cut in IP options
    build_frame(0, EtypeIpv4, 7, ProtoTcp, 5, 2, -1);      // IP options
    build_frame(0, EtypeIpv4, 5, ProtoTcp, 5, 0, 40);      // TCP short
    build_frame(0, EtypeIpv4, 5, ProtoTcp, 15, 0, 70);     // cut in TCP options
    build_frame(0, EtypeIpv4, 5, ProtoTcp, 2, 5, -1);      // small data offset
    build_frame(0, EtypeIpv4, 5, ProtoTcp, 0, 0, -1);
    build_frame(0, EtypeIpv4, 15, ProtoTcp, 15, 1, -1);    // both maximal
    build_frame(3, EtypeIpv4, 5, ProtoTcp, 5, 0, -1);      // stacked VLANs
    while (byte_q.size() < 1950) begin
      if ($urandom_range(0, 3) != 0)
        build_frame(($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0,
                    EtypeIpv4, 4'($urandom_range(5, 8)), ProtoTcp,
                    4'($urandom_range(5, 10)), $urandom_range(0, 24), -1);
      else
        build_frame($urandom_range(0, 2),
                    ($urandom_range(0, 2) == 0) ? 16'($urandom) : EtypeIpv4,
                    4'($urandom), ($urandom_range(0, 1) == 0) ? ProtoTcp : 8'($urandom),
                    4'($urandom), $urandom_range(0, 8), $urandom_range(1, 80));
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (byte_q.size() != 0 || result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && result_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
